/* hdl/priority_schedule_chart_core_defines.svh */
// Assertion macros for the priority schedule chart core.
`ifndef PRIORITY_SCHEDULE_CHART_CORE_DEFINES_SVH
`define PRIORITY_SCHEDULE_CHART_CORE_DEFINES_SVH
`ifndef SYNTH
`define PSC_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("psc: invariant violated");
`define PSC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psc: implication violated");
`else
`define PSC_ASSERT_HOLDS(label, clk, rst, expr)
`define PSC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/psc_pkg.sv */
// Shared types and constants of the priority schedule chart core.
package psc_pkg;

   localparam int MaxProcs   = 16;
   localparam int MaxResults = 48;
   localparam int IdxW       = $clog2(MaxProcs);
   localparam int CntW       = $clog2(MaxProcs + 1);
   localparam int ResW       = $clog2(MaxResults + 1);
   localparam int TimeW      = 21;
   localparam int IdW        = 8;
   localparam int ArrW       = 16;
   localparam int BurstW     = 16;
   localparam int PrioW      = 8;

   typedef struct packed {
      logic [IdW-1:0]    id;
      logic [ArrW-1:0]   arrival;
      logic [BurstW-1:0] burst;
      logic [PrioW-1:0]  prio;
   } proc_entry_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_PRE,
      ST_DEC,
      ST_PUSH,
      ST_FIN
   } state_type;

endpackage

/* hdl/priority_schedule_chart_core.sv */
// Each request is written to the table while loading, up to MaxProcs entries. A running section
// takes a table scan, a second scan for preemption in preemptive mode, then a decide step and a
// push step; an idle section takes a scan and a push. All scans share the single table read port.
// One section is held back so the last can be marked; the walk ends with a finish step.
// Sections stream out through a one-deep output register; a push waits while it is full.
// Synchronous reset clears control state, count, time and mode; the table is undefined.
`include "priority_schedule_chart_core_defines.svh"

module priority_schedule_chart_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_proc_id,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_length,
   input  logic [7:0]  req_priority_level,
   input  logic        req_last_process,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_section_start,
   output logic [20:0] rsp_section_end,
   output logic [7:0]  rsp_section_process,
   output logic        rsp_last_section,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam int TW = psc_pkg::TimeW;
   localparam int IW = psc_pkg::IdxW;
   localparam int CW = psc_pkg::CntW;
   localparam int RW = psc_pkg::ResW;
   localparam int BW = psc_pkg::BurstW;

   psc_pkg::proc_entry_type table_ff [psc_pkg::MaxProcs];
   psc_pkg::proc_entry_type rdata_ff;

   psc_pkg::state_type state_ff, state_in;

   logic          mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] time_ff, time_in;
   logic [RW-1:0] k_ff, k_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic          dv_ff, dv_in;
   logic [IW-1:0] dix_ff, dix_in;
   logic          found_ff, found_in;
   logic          any_ff, any_in;
   logic [TW-1:0] na_ff, na_in;
   logic [IW-1:0] best_ff, best_in;
   psc_pkg::proc_entry_type bent_ff, bent_in;
   logic [TW-1:0] end_ff, end_in;
   logic [TW-1:0] ns_start_ff, ns_start_in;
   logic [TW-1:0] ns_end_ff, ns_end_in;
   logic [7:0]    ns_proc_ff, ns_proc_in;
   logic [TW-1:0] pd_start_ff, pd_start_in;
   logic [TW-1:0] pd_end_ff, pd_end_in;
   logic [7:0]    pd_proc_ff, pd_proc_in;
   logic          pd_vld_ff, pd_vld_in;
   logic          rv_ff, rv_in;
   logic [TW-1:0] r_start_ff, r_start_in;
   logic [TW-1:0] r_end_ff, r_end_in;
   logic [7:0]    r_proc_ff, r_proc_in;
   logic          r_last_ff, r_last_in;

   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   psc_pkg::proc_entry_type wr_data;

   logic          scan_done;
   logic          slot_free;
   logic          load_go;
   logic          idle_gap;
   logic [TW-1:0] q_arr;

   assign scan_done = (iss_ff == count_ff) && !dv_ff;
   assign slot_free = !rv_ff || rsp_ready;
   assign load_go   = req_valid && req_ready;
   assign idle_gap  = !found_ff && any_ff;
   assign q_arr     = TW'(rdata_ff.arrival);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psc_pkg::ST_LOAD: begin
            if (load_go && req_last_process) state_in = psc_pkg::ST_SCAN;
         end
         psc_pkg::ST_SCAN: begin
            if (scan_done) begin
               priority if (k_ff == RW'(psc_pkg::MaxResults) || (!found_ff && !any_ff))
                  state_in = psc_pkg::ST_FIN;
               else if (!found_ff)
                  state_in = psc_pkg::ST_PUSH;
               else if (mode_ff)
                  state_in = psc_pkg::ST_PRE;
               else
                  state_in = psc_pkg::ST_DEC;
            end
         end
         psc_pkg::ST_PRE: begin
            if (scan_done) state_in = psc_pkg::ST_DEC;
         end
         psc_pkg::ST_DEC: state_in = psc_pkg::ST_PUSH;
         psc_pkg::ST_PUSH: begin
            if (slot_free) state_in = psc_pkg::ST_SCAN;
         end
         psc_pkg::ST_FIN: begin
            if (slot_free) state_in = psc_pkg::ST_LOAD;
         end
         default: state_in = psc_pkg::ST_LOAD;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready = (state_ff == psc_pkg::ST_LOAD);
   end

   // datapath
   always_comb begin
      mode_in     = csr_write_enable ? csr_write_data : mode_ff;
      count_in    = count_ff;
      time_in     = time_ff;
      k_in        = k_ff;
      iss_in      = iss_ff;
      dv_in       = 1'b0;
      dix_in      = dix_ff;
      found_in    = found_ff;
      any_in      = any_ff;
      na_in       = na_ff;
      best_in     = best_ff;
      bent_in     = bent_ff;
      end_in      = end_ff;
      ns_start_in = ns_start_ff;
      ns_end_in   = ns_end_ff;
      ns_proc_in  = ns_proc_ff;
      pd_start_in = pd_start_ff;
      pd_end_in   = pd_end_ff;
      pd_proc_in  = pd_proc_ff;
      pd_vld_in   = pd_vld_ff;
      rv_in       = rv_ff && !rsp_ready;
      r_start_in  = r_start_ff;
      r_end_in    = r_end_ff;
      r_proc_in   = r_proc_ff;
      r_last_in   = r_last_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[IW-1:0];
      wr_data     = '{id: req_proc_id, arrival: req_arrival_time,
                      burst: req_burst_length, prio: req_priority_level};

      // issue table reads while a scan is running
      if ((state_ff == psc_pkg::ST_SCAN || state_ff == psc_pkg::ST_PRE)
          && iss_ff != count_ff) begin
         iss_in = iss_ff + CW'(1);
         dv_in  = 1'b1;
         dix_in = iss_ff[IW-1:0];
      end

      unique case (state_ff)
         psc_pkg::ST_LOAD: begin
            if (load_go) begin
               if (count_ff < CW'(psc_pkg::MaxProcs)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               if (req_last_process) begin
                  time_in  = '0;
                  k_in     = '0;
                  iss_in   = '0;
                  found_in = 1'b0;
                  any_in   = 1'b0;
               end
            end
         end
         psc_pkg::ST_SCAN: begin
            if (dv_ff && rdata_ff.burst != '0) begin
               if (q_arr <= time_ff) begin
                  // strict compare keeps the lowest index on a tie
                  if (!found_ff || rdata_ff.prio > bent_ff.prio) begin
                     found_in = 1'b1;
                     best_in  = dix_ff;
                     bent_in  = rdata_ff;
                  end
               end else if (!any_ff || q_arr < na_ff) begin
                  any_in = 1'b1;
                  na_in  = q_arr;
               end
            end
            if (scan_done) begin
               end_in = time_ff + TW'(bent_ff.burst);
               iss_in = '0;
               if (idle_gap && k_ff != RW'(psc_pkg::MaxResults)) begin
                  ns_start_in = time_ff;
                  ns_end_in   = na_ff;
                  ns_proc_in  = '0;
                  time_in     = na_ff;
                  k_in        = k_ff + RW'(1);
               end
            end
         end
         psc_pkg::ST_PRE: begin
            // cut the section at the earliest higher-priority arrival
            if (dv_ff && rdata_ff.burst != '0 && rdata_ff.prio > bent_ff.prio
                && q_arr > time_ff && q_arr < end_ff)
               end_in = q_arr;
         end
         psc_pkg::ST_DEC: begin
            wr_en         = 1'b1;
            wr_addr       = best_ff;
            wr_data       = bent_ff;
            wr_data.burst = bent_ff.burst - BW'(end_ff - time_ff);
            ns_start_in   = time_ff;
            ns_end_in     = end_ff;
            ns_proc_in    = bent_ff.id;
            time_in       = end_ff;
            k_in          = k_ff + RW'(1);
         end
         psc_pkg::ST_PUSH: begin
            if (slot_free) begin
               if (pd_vld_ff) begin
                  rv_in      = 1'b1;
                  r_start_in = pd_start_ff;
                  r_end_in   = pd_end_ff;
                  r_proc_in  = pd_proc_ff;
                  r_last_in  = 1'b0;
               end
               pd_vld_in   = 1'b1;
               pd_start_in = ns_start_ff;
               pd_end_in   = ns_end_ff;
               pd_proc_in  = ns_proc_ff;
               iss_in      = '0;
               found_in    = 1'b0;
               any_in      = 1'b0;
            end
         end
         psc_pkg::ST_FIN: begin
            if (slot_free) begin
               if (pd_vld_ff) begin
                  rv_in      = 1'b1;
                  r_start_in = pd_start_ff;
                  r_end_in   = pd_end_ff;
                  r_proc_in  = pd_proc_ff;
                  r_last_in  = 1'b1;
               end
               pd_vld_in = 1'b0;
               count_in  = '0;
               time_in   = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) table_ff[wr_addr] <= wr_data;
      rdata_ff <= table_ff[iss_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= psc_pkg::ST_LOAD;
         mode_ff   <= 1'b0;
         count_ff  <= '0;
         time_ff   <= '0;
         k_ff      <= '0;
         iss_ff    <= '0;
         dv_ff     <= 1'b0;
         found_ff  <= 1'b0;
         any_ff    <= 1'b0;
         pd_vld_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         time_ff   <= time_in;
         k_ff      <= k_in;
         iss_ff    <= iss_in;
         dv_ff     <= dv_in;
         found_ff  <= found_in;
         any_ff    <= any_in;
         pd_vld_ff <= pd_vld_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      dix_ff      <= dix_in;
      na_ff       <= na_in;
      best_ff     <= best_in;
      bent_ff     <= bent_in;
      end_ff      <= end_in;
      ns_start_ff <= ns_start_in;
      ns_end_ff   <= ns_end_in;
      ns_proc_ff  <= ns_proc_in;
      pd_start_ff <= pd_start_in;
      pd_end_ff   <= pd_end_in;
      pd_proc_ff  <= pd_proc_in;
      r_start_ff  <= r_start_in;
      r_end_ff    <= r_end_in;
      r_proc_ff   <= r_proc_in;
      r_last_ff   <= r_last_in;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_section_start   = r_start_ff;
   assign rsp_section_end     = r_end_ff;
   assign rsp_section_process = r_proc_ff;
   assign rsp_last_section    = r_last_ff;

   `PSC_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CW'(psc_pkg::MaxProcs))
   `PSC_ASSERT_HOLDS(a_sections_bound, clock, reset, k_ff <= RW'(psc_pkg::MaxResults))
   `PSC_ASSERT_IMPLIES(a_section_order, clock, reset, rv_ff, r_end_ff >= r_start_ff)
   `PSC_ASSERT_IMPLIES(a_no_pending_in_load, clock, reset, state_ff == psc_pkg::ST_LOAD, !pd_vld_ff)
   `PSC_ASSERT_IMPLIES(a_read_in_scan, clock, reset, dv_ff, state_ff == psc_pkg::ST_SCAN || state_ff == psc_pkg::ST_PRE)

endmodule

/* dv/tb_priority_schedule_chart_core.sv */
// Testbench for the priority schedule chart core: directed and random process sets.
`timescale 1ns / 1ps

module tb_priority_schedule_chart_core;

   localparam int CycleLimit = 10000000;
   localparam int DrainWait  = 300;

   typedef struct {
      logic [psc_pkg::TimeW-1:0] start;
      logic [psc_pkg::TimeW-1:0] stop;
      logic [psc_pkg::IdW-1:0]   pid;
      logic                      last;
   } section_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [psc_pkg::IdW-1:0]    req_proc_id;
   logic [psc_pkg::ArrW-1:0]   req_arrival_time;
   logic [psc_pkg::BurstW-1:0] req_burst_length;
   logic [psc_pkg::PrioW-1:0]  req_priority_level;
   logic                       req_last_process;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [psc_pkg::TimeW-1:0]  rsp_section_start;
   logic [psc_pkg::TimeW-1:0]  rsp_section_end;
   logic [psc_pkg::IdW-1:0]    rsp_section_process;
   logic                       rsp_last_section;
   logic                       csr_write_enable;
   logic                       csr_write_data;

   // predictor state
   logic [psc_pkg::IdW-1:0]    tbl_id    [psc_pkg::MaxProcs];
   logic [psc_pkg::ArrW-1:0]   tbl_arr   [psc_pkg::MaxProcs];
   logic [psc_pkg::BurstW-1:0] tbl_burst [psc_pkg::MaxProcs];
   logic [psc_pkg::PrioW-1:0]  tbl_prio  [psc_pkg::MaxProcs];
   int                         tbl_count;
   bit                         preempt_mode;

   section_type       chart_q[$];
   int                errors;
   int                request_total;
   bit                calm;
   int                ready_hold;
   longint            cycles;

   priority_schedule_chart_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_proc_id        (req_proc_id),
      .req_arrival_time   (req_arrival_time),
      .req_burst_length   (req_burst_length),
      .req_priority_level (req_priority_level),
      .req_last_process   (req_last_process),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_section_start  (rsp_section_start),
      .rsp_section_end    (rsp_section_end),
      .rsp_section_process(rsp_section_process),
      .rsp_last_section   (rsp_last_section),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   // Walk the stored table and queue every chart section it yields.
   function automatic void build_chart();
      int unsigned rem [psc_pkg::MaxProcs];
      int unsigned now, stop, next_arr;
      int          k, best, i;
      bit          any, found;
      section_type s;
      section_type sec_q[$];
      for (i = 0; i < tbl_count; i++) rem[i] = 32'(tbl_burst[i]);
      now = 0;
      k = 0;
      while (k < psc_pkg::MaxResults) begin
         any = 0;
         found = 0;
         best = 0;
         next_arr = 0;
         for (i = 0; i < tbl_count; i++) begin
            if (rem[i] == 0) continue;
            if (32'(tbl_arr[i]) <= now) begin
               if (!found || tbl_prio[i] > tbl_prio[best]) begin
                  best = i;
                  found = 1;
               end
            end else if (!any || 32'(tbl_arr[i]) < next_arr) begin
               next_arr = 32'(tbl_arr[i]);
               any = 1;
            end
         end
         if (!found && !any) break;
         if (!found) begin
            s = '{start: psc_pkg::TimeW'(now), stop: psc_pkg::TimeW'(next_arr),
                  pid: '0, last: 1'b0};
            sec_q = {sec_q, s};
            k++;
            now = next_arr;
            continue;
         end
         stop = now + rem[best];
         if (preempt_mode) begin
            for (i = 0; i < tbl_count; i++) begin
               if (rem[i] != 0 && tbl_prio[i] > tbl_prio[best]
                   && 32'(tbl_arr[i]) > now && 32'(tbl_arr[i]) < stop)
                  stop = 32'(tbl_arr[i]);
            end
         end
         s = '{start: psc_pkg::TimeW'(now), stop: psc_pkg::TimeW'(stop),
               pid: tbl_id[best], last: 1'b0};
         sec_q = {sec_q, s};
         k++;
         rem[best] -= stop - now;
         now = stop;
      end
      if (sec_q.size() > 0) sec_q[$].last = 1'b1;
      chart_q = {chart_q, sec_q};
      tbl_count = 0;
   endfunction

   task automatic send_request(input logic [psc_pkg::IdW-1:0] id,
                               input logic [psc_pkg::ArrW-1:0] arr,
                               input logic [psc_pkg::BurstW-1:0] burst,
                               input logic [psc_pkg::PrioW-1:0] prio,
                               input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_proc_id        <= id;
      req_arrival_time   <= arr;
      req_burst_length   <= burst;
      req_priority_level <= prio;
      req_last_process   <= last;
      do @(posedge clock); while (!req_ready);
      request_total++;
      if (tbl_count < psc_pkg::MaxProcs) begin
         tbl_id[tbl_count]    = id;
         tbl_arr[tbl_count]   = arr;
         tbl_burst[tbl_count] = burst;
         tbl_prio[tbl_count]  = prio;
         tbl_count++;
      end
      if (last) build_chart();
   endtask

   // Drain outstanding sections and let a silent walk finish before touching the mode.
   task automatic write_mode(input bit mode);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (chart_q.size() == 0);
      repeat (DrainWait) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      preempt_mode = mode;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_non_preemptive();
      write_mode(1'b0);
      send_request(8'd1, 16'd0, 16'd5, 8'd1, 1'b1);
      // leading idle and a gap between arrivals
      send_request(8'd7, 16'd10, 16'd3, 8'd2, 1'b0);
      send_request(8'd8, 16'd20, 16'd4, 8'd9, 1'b1);
      // only zero bursts: no chart
      send_request(8'd3, 16'd0, 16'd0, 8'd5, 1'b1);
      send_request(8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 1'b0);
      send_request(8'd0, 16'd0, 16'hFFFF, 8'd0, 1'b1);
   endtask

   task automatic test_preemptive();
      write_mode(1'b1);
      send_request(8'd1, 16'd0, 16'd10, 8'd1, 1'b0);
      send_request(8'd2, 16'd3, 16'd4, 8'd5, 1'b0);
      send_request(8'd3, 16'd5, 16'd2, 8'd5, 1'b1);
      send_request(8'd4, 16'd0, 16'd2, 8'd3, 1'b0);
      send_request(8'd5, 16'd0, 16'd2, 8'd3, 1'b1);
   endtask

   task automatic test_random_sets();
      int n, i, phase_end, r;
      logic [psc_pkg::ArrW-1:0]   arr;
      logic [psc_pkg::BurstW-1:0] burst;
      logic [psc_pkg::PrioW-1:0]  prio;
      logic [psc_pkg::IdW-1:0]    id;
      while (request_total < 395) begin
         write_mode(1'($urandom_range(0, 1)));
         calm = ($urandom_range(0, 3) == 0);
         phase_end = request_total + $urandom_range(30, 70);
         while (request_total < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 70) n = $urandom_range(1, 6);
            else if (r < 92) n = $urandom_range(7, 16);
            else n = $urandom_range(17, 20);
            for (i = 0; i < n; i++) begin
               r = $urandom_range(0, 99);
               arr   = (r < 85) ? psc_pkg::ArrW'($urandom_range(0, 40))
                                : psc_pkg::ArrW'($urandom_range(0, 16'hFFFF));
               r = $urandom_range(0, 99);
               burst = (r < 10) ? 16'd0 :
                       (r < 90) ? psc_pkg::BurstW'($urandom_range(1, 20))
                                : psc_pkg::BurstW'($urandom_range(0, 16'hFFFF));
               prio  = ($urandom_range(0, 1) == 0) ? psc_pkg::PrioW'($urandom_range(1, 4))
                                                   : psc_pkg::PrioW'($urandom_range(0, 255));
               id    = psc_pkg::IdW'($urandom_range(0, 255));
               send_request(id, arr, burst, prio, i == n - 1);
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      section_type exp_s;
      if (!reset && rsp_valid && rsp_ready) begin
         if (chart_q.size() == 0) begin
            report($sformatf("unexpected section %0d..%0d pid %0d",
                             rsp_section_start, rsp_section_end, rsp_section_process));
         end else begin
            exp_s = chart_q.pop_front();
            if (rsp_section_start !== exp_s.start)
               report($sformatf("start %0d, want %0d", rsp_section_start, exp_s.start));
            if (rsp_section_end !== exp_s.stop)
               report($sformatf("end %0d, want %0d", rsp_section_end, exp_s.stop));
            if (rsp_section_process !== exp_s.pid)
               report($sformatf("process %0d, want %0d", rsp_section_process, exp_s.pid));
            if (rsp_last_section !== exp_s.last)
               report($sformatf("last %0b, want %0b", rsp_last_section, exp_s.last));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("priority_schedule_chart_core: mismatch");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_proc_id        = '0;
      req_arrival_time   = '0;
      req_burst_length   = '0;
      req_priority_level = '0;
      req_last_process   = 1'b0;
      rsp_ready          = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      tbl_count          = 0;
      preempt_mode       = 1'b0;
      errors             = 0;
      request_total      = 0;
      calm               = 1'b0;
      ready_hold         = 0;
      cycles             = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_non_preemptive();
      test_preemptive();
      test_random_sets();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (chart_q.size() == 0);
      repeat (DrainWait) @(posedge clock);
      if (errors == 0) begin
         $display("priority_schedule_chart_core: match");
      end else begin
         $display("priority_schedule_chart_core: mismatch");
      end
      $finish;
   end

endmodule
